// ----- sv/gauss_seidel_heat_relaxation_assert.svh -----
// Assertion macros shared by the heat relaxation RTL.
`ifndef GAUSS_SEIDEL_HEAT_RELAXATION_ASSERT_SVH
`define GAUSS_SEIDEL_HEAT_RELAXATION_ASSERT_SVH

`ifndef ASSERT_OFF

`define GSHR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gshr assertion failed");

`define GSHR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gshr assertion failed");

`else

`define GSHR_ASSERT(label, clk, rst, prop)

`define GSHR_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ----- sv/gshr_pkg.sv -----
// Shared types and constants of the heat relaxation block.
`timescale 1ns / 1ps

package gshr_pkg;

  localparam int CELL_W = 24;
  localparam int GS_W   = 6;
  localparam int TOL_W  = 23;

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_SWEEP = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  localparam logic CFG_GRID_SIZE = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  localparam logic [GS_W-1:0]  GRID_SIZE_RESET = 6'd20;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 23'd1;

  localparam cell_t CELL_MAX = 24'sh7FFFFF;
  localparam cell_t CELL_MIN = 24'sh800000;

  typedef struct packed {
    logic  done;
    cell_t value;
  } edge_res_t;

endpackage

// ----- sv/gshr_edge.sv -----
// Boundary value unit: ((2c-d)/d)^3 in fixed point, one quotient bit per cycle.
`timescale 1ns / 1ps

module gshr_edge #(
  parameter int IW        = 5,
  parameter int FRAC_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IW-1:0]       col,
  input  logic [IW-1:0]       dim,
  output gshr_pkg::edge_res_t res
);
  import gshr_pkg::*;

  localparam int DW = 3 * IW;
  localparam int RW = DW + 1;
  localparam int QW = FRAC_BITS + 2;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int XW = (QW > CELL_W + 1) ? QW : CELL_W + 1;

  localparam logic [XW-1:0] POS_LIM = XW'(25'h07FFFFF);
  localparam logic [XW-1:0] NEG_LIM = XW'(25'h0800000);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_SQ   = 3'd1;
  localparam logic [2:0] E_CUBE = 3'd2;
  localparam logic [2:0] E_INIT = 3'd3;
  localparam logic [2:0] E_DIV  = 3'd4;
  localparam logic [2:0] E_RND  = 3'd5;

  logic [2:0]      state;
  logic [IW-1:0]   mag;
  logic            neg;
  logic [IW-1:0]   dmul;
  logic [2*IW-1:0] sq;
  logic [2*IW-1:0] dsq;
  logic [DW-1:0]   num;
  logic [DW-1:0]   den;
  logic [RW-1:0]   rem;
  logic [QW-1:0]   q;
  logic [CW-1:0]   cnt;
  logic            done;
  cell_t           value;

  logic [IW:0]     twice_c;
  logic [IW:0]     dext;
  logic            ge;
  logic [IW-1:0]   mag_calc;
  logic [RW-1:0]   rem2;
  logic            fits;
  logic [QW-1:0]   qr;
  logic [XW-1:0]   qx;
  cell_t           val_calc;

  always_comb begin
    twice_c  = {col, 1'b0};
    dext     = {1'b0, dim};
    ge       = twice_c >= dext;
    mag_calc = ge ? IW'(twice_c - dext) : IW'(dext - twice_c);
    rem2     = {rem[RW-2:0], 1'b0};
    fits     = rem2 >= {1'b0, den};
    qr       = (q + QW'(1)) >> 1;
    qx       = XW'(qr);
    if (neg) begin
      val_calc = (qx > NEG_LIM) ? CELL_MIN : cell_t'(-qx[CELL_W-1:0]);
    end else begin
      val_calc = (qx > POS_LIM) ? CELL_MAX : cell_t'(qx[CELL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            mag   <= mag_calc;
            neg   <= !ge;
            dmul  <= dim;
            state <= E_SQ;
          end
        end
        E_SQ: begin
          sq    <= mag * mag;
          dsq   <= dmul * dmul;
          state <= E_CUBE;
        end
        E_CUBE: begin
          num   <= sq * mag;
          den   <= dsq * dmul;
          state <= E_INIT;
        end
        E_INIT: begin
          if (num >= den) begin
            q   <= QW'(1);
            rem <= RW'(num - den);
          end else begin
            q   <= '0;
            rem <= RW'(num);
          end
          cnt   <= '0;
          state <= E_DIV;
        end
        E_DIV: begin
          rem <= fits ? rem2 - {1'b0, den} : rem2;
          q   <= {q[QW-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS)) begin
            state <= E_RND;
          end
        end
        E_RND: begin
          value <= val_calc;
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_comb begin
    res.done  = done;
    res.value = value;
  end

endmodule

// ----- sv/gauss_seidel_heat_relaxation.sv -----
// Top level: in-place five-point heat relaxation over a grid held in block RAM.
`timescale 1ns / 1ps
`include "gauss_seidel_heat_relaxation_assert.svh"

// Gauss-Seidel heat relaxation. The grid (MAX_DIM x MAX_DIM cells, 24-bit
// signed, FRAC_BITS fraction bits) sits in one RAM with one write and two
// registered read ports; one item is worked at a time and a finished result
// waits in the output register while the next transaction is taken. After
// reset a clearing pass zeroes the RAM with in_stall high; config writes are
// taken throughout. A clear item runs that clearing pass again and a read
// item reads one cell through a registered read port. A sweep over an n x n
// grid works the top row first, where each boundary value comes out of an
// iterative divider one quotient bit per cycle; each inner cell goes through
// two reads on the RAM, the add, the multiply by the reciprocal of five and
// the write-back; a side cell is set to minus or plus one, and a bottom-row
// cell is copied from the top row. Grid sizes outside 3..MAX_DIM are
// clamped.
module gauss_seidel_heat_relaxation #(
  parameter int MAX_DIM   = 32,
  parameter int FRAC_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gshr_pkg::kind_t      kind,
  input  logic [4:0]           row,
  input  logic [4:0]           col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 converged,
  output gshr_pkg::cell_t      cell_value,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [22:0]          cfg_data
);
  import gshr_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = CELL_W + 3;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP5 = 32'hCCCCCCCD;

  localparam cell_t ONE_POS = (FRAC_BITS >= CELL_W - 1) ? CELL_MAX
                                                        : cell_t'(64'd1 << FRAC_BITS);
  localparam cell_t ONE_NEG = (FRAC_BITS >= CELL_W - 1) ? CELL_MIN : -ONE_POS;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_CELL = 4'd4;
  localparam logic [3:0] S_EW   = 4'd5;
  localparam logic [3:0] S_CPW  = 4'd6;
  localparam logic [3:0] S_RB   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [GS_W-1:0]  grid_size;
  logic [TOL_W-1:0] tolerance;

  logic [3:0]    state;
  logic [AW-1:0] cur;
  logic [IW-1:0] r;
  logic [IW-1:0] c;
  logic [IW-1:0] d;
  logic          reply;
  logic          conv;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic          res_conv;
  cell_t         res_value;

  cell_t         old;
  cell_t         left;
  logic [SW-1:0] sum;
  logic [CELL_W-1:0] q5;
  logic          neg5;

  cell_t         mem [DEPTH];
  cell_t         q0;
  cell_t         q1;
  logic          we;
  logic [AW-1:0] waddr;
  cell_t         wdata;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;

  logic          edge_start;
  edge_res_t     edge_res;

  logic [IW-1:0] dim_calc;
  logic          in_accept;
  logic          out_load;
  logic          side_cell;
  logic          cell_done;
  logic [SW-1:0] sum_abs;
  logic [SW+RECIP_W-2:0] prod;
  cell_t         nv;
  logic [CELL_W:0] diff;
  logic [CELL_W:0] absd;

  gshr_edge #(
    .IW        (IW),
    .FRAC_BITS (FRAC_BITS)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (edge_start),
    .col   (c),
    .dim   (d),
    .res   (edge_res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RESET;
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRID_SIZE: grid_size <= cfg_data[GS_W-1:0];
        CFG_TOLERANCE: tolerance <= cfg_data;
      endcase
    end
  end

  always_comb begin
    priority if (grid_size < GS_W'(3)) begin
      dim_calc = IW'(2);
    end else if (32'(grid_size) > MAX_DIM) begin
      dim_calc = IW'(MAX_DIM - 1);
    end else begin
      dim_calc = IW'(grid_size - GS_W'(1));
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  assign side_cell  = (r != '0) && (r != d) && ((c == '0) || (c == d));
  assign edge_start = (state == S_CELL) && (r == '0);

  always_comb begin
    cell_done = 1'b0;
    unique case (state)
      S_CELL:  cell_done = side_cell;
      S_EW:    cell_done = edge_res.done;
      S_CPW:   cell_done = 1'b1;
      S_WR:    cell_done = 1'b1;
      default: cell_done = 1'b0;
    endcase
  end

  // datapath of the inner update
  always_comb begin
    sum_abs = sum[SW-1] ? SW'(-sum) : sum;
    prod    = sum_abs[SW-2:0] * RECIP5;
    nv      = neg5 ? cell_t'(-q5) : cell_t'(q5);
    diff    = {old[CELL_W-1], old} - {nv[CELL_W-1], nv};
    absd    = diff[CELL_W] ? (CELL_W+1)'(-diff) : diff;
  end

  // RAM port control
  always_comb begin
    we     = 1'b0;
    waddr  = cur;
    wdata  = '0;
    raddr0 = '0;
    raddr1 = '0;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_RD: begin
        raddr0 = rd_addr;
      end
      S_CELL: begin
        if (r == d) begin
          raddr0 = AW'(c);
        end else if (side_cell) begin
          we    = 1'b1;
          wdata = (c == '0) ? ONE_NEG : ONE_POS;
        end else begin
          raddr0 = cur;
          raddr1 = cur + AW'(1);
        end
      end
      S_EW: begin
        we    = edge_res.done;
        wdata = edge_res.value;
      end
      S_CPW: begin
        we    = 1'b1;
        wdata = q0;
      end
      S_RB: begin
        raddr0 = cur - AW'(MAX_DIM);
        raddr1 = cur + AW'(MAX_DIM);
      end
      S_WR: begin
        we    = 1'b1;
        wdata = nv;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q0 <= mem[raddr0];
    q1 <= mem[raddr1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cur   <= '0;
      r     <= '0;
      c     <= '0;
      d     <= IW'(2);
      reply <= 1'b0;
      conv  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (we) begin
        left <= wdata;
      end
      unique case (state)
        S_CLR: begin
          cur <= cur + AW'(1);
          if (cur == AW'(DEPTH - 1)) begin
            res_conv  <= 1'b0;
            res_value <= '0;
            state     <= reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            unique case (kind)
              KIND_CLEAR: begin
                cur   <= '0;
                reply <= 1'b1;
                state <= S_CLR;
              end
              KIND_SWEEP: begin
                d     <= dim_calc;
                r     <= '0;
                c     <= '0;
                cur   <= '0;
                conv  <= 1'b1;
                state <= S_CELL;
              end
              KIND_READ: begin
                rd_addr <= AW'(32'(row) * MAX_DIM + 32'(col));
                rd_ok   <= (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
                state   <= S_RD;
              end
              default: begin
                res_conv  <= 1'b0;
                res_value <= '0;
                state     <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          res_conv  <= 1'b0;
          res_value <= rd_ok ? q0 : '0;
          state     <= S_DONE;
        end
        S_CELL: begin
          priority if (r == '0) begin
            state <= S_EW;
          end else if (r == d) begin
            state <= S_CPW;
          end else if (!side_cell) begin
            state <= S_RB;
          end
        end
        S_EW, S_CPW: begin
        end
        S_RB: begin
          old   <= q0;
          sum   <= {{3{q0[CELL_W-1]}}, q0} + {{3{q1[CELL_W-1]}}, q1};
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= sum + {{3{q0[CELL_W-1]}}, q0} + {{3{q1[CELL_W-1]}}, q1}
                       + {{3{left[CELL_W-1]}}, left};
          state <= S_MUL;
        end
        S_MUL: begin
          neg5  <= sum[SW-1];
          q5    <= prod[RECIP_SHIFT +: CELL_W];
          state <= S_WR;
        end
        S_WR: begin
          if (absd >= (CELL_W+1)'(tolerance)) begin
            conv <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_load) begin
            reply <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // step to the next cell in row-major order
      if (cell_done) begin
        if (c == d) begin
          c   <= '0;
          r   <= r + 1'b1;
          cur <= cur + AW'(MAX_DIM) - AW'(d);
          if (r == d) begin
            res_conv  <= conv;
            res_value <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_CELL;
          end
        end else begin
          c     <= c + 1'b1;
          cur   <= cur + AW'(1);
          state <= S_CELL;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      converged  <= res_conv;
      cell_value <= res_value;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `GSHR_ASSERT(a_conv_no_value, clk, rst, out_valid && converged |-> cell_value == '0)
  `GSHR_ASSERT(a_edge_done_wait, clk, rst, edge_res.done |-> state == S_EW)
  `GSHR_ASSERT(a_waddr_range, clk, rst, we |-> 32'(waddr) < DEPTH)
  `GSHR_ASSERT(a_col_bound, clk, rst, state == S_CELL |-> c <= d)
  `GSHR_ASSERT_NEXT(a_wr_step, clk, rst, state == S_WR, state == S_CELL || state == S_DONE)

endmodule
